// ===== rtl/rpr_pkg.sv =====
// Shared types, constants and the saturation helper for the rotary pair rotator.
// No dependencies; every other file imports this package.
package rpr_pkg;

  localparam int unsigned FracBits = 14;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_ROTATE = 1'b1
  } cmd_t;

  typedef logic signed [15:0] elem_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [33:0] acc_t;
  typedef logic signed [19:0] scaled_t;

  typedef struct packed {
    elem_t cos_q;
    elem_t sin_q;
  } angle_t;

  typedef struct packed {
    elem_t low;
    elem_t high;
  } pair_t;

  typedef struct packed {
    cmd_t   cmd;
    logic   in_range;
    angle_t angle;
    pair_t  pair;
  } s1_item_t;

  typedef struct packed {
    logic   in_range;
    angle_t angle;
    pair_t  pair;
  } rot_item_t;

  typedef struct packed {
    elem_t value;
    logic  clip;
  } sat_t;

  localparam acc_t    RoundHalf = acc_t'(34'sd8192);
  localparam scaled_t SatMax    = scaled_t'(20'sd32767);
  localparam scaled_t SatMin    = scaled_t'(-20'sd32768);

  function automatic sat_t sat16(scaled_t v);
    sat_t r;
    r.clip  = 1'b0;
    r.value = elem_t'(v);
    if (v > SatMax) begin
      r.clip  = 1'b1;
      r.value = elem_t'(16'sh7fff);
    end else if (v < SatMin) begin
      r.clip  = 1'b1;
      r.value = elem_t'(16'sh8000);
    end
    return r;
  endfunction

endpackage

// ===== rtl/rpr_table.sv =====
// Angle table stage: writes cos/sin entries on in-range loads, reads them on rotate.
// Depends on rpr_pkg.
module rpr_table import rpr_pkg::*; #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned AW    = 17
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s_valid,
  output logic      s_ready,
  input  s1_item_t  s_item,
  input  logic [AW-1:0] s_addr,
  output logic      m_valid,
  input  logic      m_ready,
  output rot_item_t m_item
);

  angle_t    mem [DEPTH];
  logic      s2_v_r;
  angle_t    rd_r;
  logic      in_range_r;
  pair_t     pair_r;
  logic      adv;

  assign adv     = !s2_v_r || m_ready;
  assign s_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      // loads end here; only rotates travel on
      s2_v_r <= s_valid && (s_item.cmd == CMD_ROTATE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_valid) begin
      if (s_item.cmd == CMD_LOAD) begin
        if (s_item.in_range) begin
          mem[s_addr] <= s_item.angle;
        end
      end else begin
        rd_r <= mem[s_addr];
      end
      in_range_r <= s_item.in_range;
      pair_r     <= s_item.pair;
    end
  end

  assign m_valid          = s2_v_r;
  assign m_item.in_range  = in_range_r;
  assign m_item.angle     = rd_r;
  assign m_item.pair      = pair_r;

endmodule

// ===== rtl/rpr_mac.sv =====
// Multiply stage and round/saturate output stage of the rotation.
// Depends on rpr_pkg.
module rpr_mac import rpr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s_valid,
  output logic      s_ready,
  input  rot_item_t s_item,
  output logic      out_valid,
  input  logic      out_stall,
  output elem_t     rotated_low,
  output elem_t     rotated_high,
  output logic      clipped
);

  logic  s3_v_r;
  prod_t p_lc_r, p_hs_r, p_hc_r, p_ls_r;
  logic  out_valid_r;
  elem_t rot_low_r, rot_high_r;
  logic  clipped_r;

  logic  adv3, adv4;
  elem_t c_q, s_q;
  acc_t  acc_lo, acc_hi;
  sat_t  sat_lo, sat_hi;

  assign adv4    = !out_valid_r || !out_stall;
  assign adv3    = !s3_v_r || adv4;
  assign s_ready = adv3;

  // an out-of-range rotate uses zero cos and sin, so its result is zero
  always_comb begin
    c_q = s_item.in_range ? s_item.angle.cos_q : elem_t'(0);
    s_q = s_item.in_range ? s_item.angle.sin_q : elem_t'(0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv3) begin
      s3_v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s_valid) begin
      p_lc_r <= s_item.pair.low  * c_q;
      p_hs_r <= s_item.pair.high * s_q;
      p_hc_r <= s_item.pair.high * c_q;
      p_ls_r <= s_item.pair.low  * s_q;
    end
  end

  always_comb begin
    acc_lo = acc_t'(p_lc_r) - acc_t'(p_hs_r) + RoundHalf;
    acc_hi = acc_t'(p_hc_r) + acc_t'(p_ls_r) + RoundHalf;
    sat_lo = sat16(scaled_t'(acc_lo[33:FracBits]));
    sat_hi = sat16(scaled_t'(acc_hi[33:FracBits]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv4) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && s3_v_r) begin
      rot_low_r  <= sat_lo.value;
      rot_high_r <= sat_hi.value;
      clipped_r  <= sat_lo.clip || sat_hi.clip;
    end
  end

  assign out_valid    = out_valid_r;
  assign rotated_low  = rot_low_r;
  assign rotated_high = rot_high_r;
  assign clipped      = clipped_r;

endmodule

// ===== rtl/rotary_pair_rotator.sv =====
// Rotary pair rotator: four register stages (address, table, multiply, round/saturate).
// A rotate passes the address, table, multiply and round/saturate registers in that order
// before its result is valid. Throughput one item per cycle while out_stall stays low, set by
// the single-port table access and one multiplier per product.
// Loads take a cycle slot and give no result. Reset (rst_n, synchronous, active low)
// empties the pipeline; table contents stay undefined until loaded.
module rotary_pair_rotator import rpr_pkg::*; #(
  parameter int unsigned MAX_POSITIONS = 2048,
  parameter int unsigned HALF_DIM      = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [10:0] in_position,
  input  logic [5:0]  in_pair_index,
  input  elem_t       in_cos_value,
  input  elem_t       in_sin_value,
  input  elem_t       in_low_element,
  input  elem_t       in_high_element,
  output logic        out_valid,
  input  logic        out_stall,
  output elem_t       out_rotated_low,
  output elem_t       out_rotated_high,
  output logic        out_clipped
);

  localparam int unsigned DEPTH = MAX_POSITIONS * HALF_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          s1_v_r;
  s1_item_t      s1_item_r;
  logic [AW-1:0] s1_addr_r;
  s1_item_t      s1_item_nxt;
  logic [AW-1:0] s1_addr_nxt;
  logic [27:0]   addr_wide;
  logic          s1_adv;
  logic          s2_ready;

  rot_item_t     s2_item;
  logic          s2_valid;
  logic          s3_ready;

  assign s1_adv   = !s1_v_r || s2_ready;
  assign in_stall = !s1_adv;

  always_comb begin
    addr_wide            = 28'(in_position) * 28'(HALF_DIM) + 28'(in_pair_index);
    s1_addr_nxt          = AW'(addr_wide);
    s1_item_nxt.cmd      = cmd_t'(in_command);
    s1_item_nxt.in_range = (17'(in_position) < 17'(MAX_POSITIONS)) &&
                           (9'(in_pair_index) < 9'(HALF_DIM));
    s1_item_nxt.angle    = '{cos_q: in_cos_value, sin_q: in_sin_value};
    s1_item_nxt.pair     = '{low: in_low_element, high: in_high_element};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_item_r <= s1_item_nxt;
      s1_addr_r <= s1_addr_nxt;
    end
  end

  rpr_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (s1_v_r),
    .s_ready (s2_ready),
    .s_item  (s1_item_r),
    .s_addr  (s1_addr_r),
    .m_valid (s2_valid),
    .m_ready (s3_ready),
    .m_item  (s2_item)
  );

  rpr_mac u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_valid      (s2_valid),
    .s_ready      (s3_ready),
    .s_item       (s2_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rotated_low  (out_rotated_low),
    .rotated_high (out_rotated_high),
    .clipped      (out_clipped)
  );

endmodule

// ===== rtl/rpr_checker.sv =====
// Port-level checks for the rotary pair rotator, bound to the top level.
// Depends on rpr_pkg and rotary_pair_rotator.
module rpr_checker import rpr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_command,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_rotated_low,
  input logic [15:0] out_rotated_high,
  input logic        out_clipped
);

  logic rot_xfer;
  assign rot_xfer = in_valid && !in_stall && (in_command == CMD_ROTATE);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rotated_low) &&
      $stable(out_rotated_high) && $stable(out_clipped))
    else $error("stalled result changed");

  // a clipped result sits on a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_rotated_low == 16'h7fff || out_rotated_low == 16'h8000 ||
      out_rotated_high == 16'h7fff || out_rotated_high == 16'h8000)
    else $error("clip flag without saturated value");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a rotate drains to the output when the output does not stall
  a_rotate_latency: assert property (@(posedge clk) disable iff (!rst_n)
    rot_xfer ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("rotate result missing");

endmodule

bind rotary_pair_rotator rpr_checker u_rpr_checker (.*);
